[rtl/escape_sequence_decoder_defines.svh]
// Assertion macros used by the decoder top level.
`ifndef ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ESD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("escape decoder implication check failed");
`define ESD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("escape decoder next-cycle check failed");
`define ESD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("escape decoder forbidden condition seen");
`else
`define ESD_ASSERT_IMPL(lbl, ante, cons)
`define ESD_ASSERT_NEXT(lbl, ante, cons)
`define ESD_ASSERT_NEVER(lbl, cond)
`endif

`endif

[rtl/esd_pkg.sv]
package esd_pkg;

  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LVL_W      = PTR_W + 1;

  localparam logic [7:0] DIGIT_BASE = 8'd48;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_A       = 8'h61;
  localparam logic [7:0] CH_B       = 8'h62;
  localparam logic [7:0] CH_F       = 8'h66;
  localparam logic [7:0] CH_N       = 8'h6E;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_T       = 8'h74;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_V       = 8'h76;
  localparam logic [7:0] CTL_BEL    = 8'd7;
  localparam logic [7:0] CTL_BS     = 8'd8;
  localparam logic [7:0] CTL_TAB    = 8'd9;
  localparam logic [7:0] CTL_LF     = 8'd10;
  localparam logic [7:0] CTL_VT     = 8'd11;
  localparam logic [7:0] CTL_FF     = 8'd12;
  localparam logic [7:0] CTL_CR     = 8'd13;
  localparam logic [2:0] UESC_RAW   = 3'd5;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_ONE  = 3'd2,
    MODE_TWO  = 3'd3,
    MODE_PASS = 3'd4
  } mode_t;

  // Up to three result bytes produced by one input byte.
  typedef struct packed {
    logic [1:0]       cnt;
    logic             last;
    logic [2:0][7:0]  data;
  } res_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic             room;
  } fifo_stat_t;

  function automatic res_t put(res_t r, logic [7:0] b);
    res_t q;
    q = r;
    unique case (r.cnt)
      2'd0: begin
        q.data[0] = b;
        q.cnt = 2'd1;
      end
      2'd1: begin
        q.data[1] = b;
        q.cnt = 2'd2;
      end
      2'd2: begin
        q.data[2] = b;
        q.cnt = 2'd3;
      end
      default: begin
        q.cnt = r.cnt;
      end
    endcase
    return q;
  endfunction

endpackage

[rtl/esd_decode.sv]
module esd_decode import esd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       item_v,
  input  logic [7:0] item_byte,
  input  logic       item_last,
  output res_t       res
);

  mode_t      mode_r, mode_nxt;
  logic [3:0] first_digit_r, first_digit_nxt;
  logic [3:0] second_digit_r, second_digit_nxt;
  logic [2:0] pass_left_r, pass_left_nxt;

  logic       is_digit;
  logic [3:0] digit;
  logic [7:0] octal_val;
  logic [7:0] held_char;
  res_t       r;

  assign is_digit  = (item_byte >= CH_ZERO) && (item_byte <= CH_NINE);
  assign digit     = item_byte[3:0];
  assign octal_val = {first_digit_r[1:0], 6'd0} + {1'b0, second_digit_r, 3'd0}
                     + {4'd0, digit};
  assign held_char = DIGIT_BASE + {4'd0, second_digit_r};

  always_comb begin
    r                = '0;
    mode_nxt         = mode_r;
    first_digit_nxt  = first_digit_r;
    second_digit_nxt = second_digit_r;
    pass_left_nxt    = pass_left_r;

    unique case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_IDLE;
        unique case (item_byte)
          CH_SLASH:  r = put(r, CH_SLASH);
          CH_QUOTE:  r = put(r, CH_QUOTE);
          CH_A:      r = put(r, CTL_BEL);
          CH_B:      r = put(r, CTL_BS);
          CH_F:      r = put(r, CTL_FF);
          CH_N:      r = put(r, CTL_LF);
          CH_R:      r = put(r, CTL_CR);
          CH_T:      r = put(r, CTL_TAB);
          CH_V:      r = put(r, CTL_VT);
          CH_BSLASH: r = put(r, CH_BSLASH);
          CH_ZERO, CH_ONE: begin
            first_digit_nxt = digit;
            mode_nxt        = MODE_ONE;
          end
          CH_U: begin
            r             = put(r, CH_BSLASH);
            r             = put(r, CH_U);
            pass_left_nxt = UESC_RAW;
            mode_nxt      = MODE_PASS;
          end
          default: begin
            r = put(r, CH_BSLASH);
            r = put(r, item_byte);
          end
        endcase
      end
      MODE_ONE: begin
        if (is_digit) begin
          second_digit_nxt = digit;
          mode_nxt         = MODE_TWO;
        end else begin
          // Malformed escape: the held 0 or 1 is dropped.
          r = put(r, CH_BSLASH);
          if (item_byte == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else begin
            mode_nxt = MODE_IDLE;
            r = put(r, item_byte);
          end
        end
      end
      MODE_TWO: begin
        if (is_digit) begin
          r        = put(r, octal_val);
          mode_nxt = MODE_IDLE;
        end else begin
          r = put(r, CH_BSLASH);
          r = put(r, held_char);
          if (item_byte == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end else begin
            mode_nxt = MODE_IDLE;
            r = put(r, item_byte);
          end
        end
      end
      MODE_PASS: begin
        r             = put(r, item_byte);
        pass_left_nxt = pass_left_r - 3'd1;
        if (pass_left_nxt == 3'd0) begin
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
        if (item_byte == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          mode_nxt = MODE_IDLE;
          r = put(r, item_byte);
        end
      end
    endcase

    if (item_last) begin
      // Flush whatever escape is still open, then start the next string clean.
      if (mode_nxt == MODE_ESC || mode_nxt == MODE_ONE) begin
        r = put(r, CH_BSLASH);
      end else if (mode_nxt == MODE_TWO) begin
        r = put(r, CH_BSLASH);
        r = put(r, DIGIT_BASE + {4'd0, second_digit_nxt});
      end
      mode_nxt         = MODE_IDLE;
      first_digit_nxt  = 4'd0;
      second_digit_nxt = 4'd0;
      pass_left_nxt    = 3'd0;
    end

    r.last = item_last;
    if (!item_v) begin
      r.cnt = 2'd0;
    end
    res = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_IDLE;
      first_digit_r  <= 4'd0;
      second_digit_r <= 4'd0;
      pass_left_r    <= 3'd0;
    end else if (item_v) begin
      mode_r         <= mode_nxt;
      first_digit_r  <= first_digit_nxt;
      second_digit_r <= second_digit_nxt;
      pass_left_r    <= pass_left_nxt;
    end
  end

endmodule

[rtl/esd_fifo.sv]
module esd_fifo import esd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  res_t       res,
  output fifo_stat_t stat,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [7:0]       data_r [FIFO_DEPTH];
  logic             last_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LVL_W-1:0] level_r, level_nxt;
  logic             pop;

  assign out_valid = (level_r != '0);
  assign out_byte  = data_r[rd_ptr_r];
  assign out_last  = last_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(res.cnt);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign level_nxt  = level_r + LVL_W'(res.cnt) - LVL_W'(pop);

  // Room for two full beats: the one in the decode register and one more.
  assign stat.level = level_r;
  assign stat.room  = (level_r <= LVL_W'(FIFO_DEPTH - 2 * MAX_RES));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (2'(k) < res.cnt) begin
        data_r[wr_ptr_r + PTR_W'(k)] <= res.data[k];
        last_r[wr_ptr_r + PTR_W'(k)] <= res.last && (2'(k + 1) == res.cnt);
      end
    end
  end

endmodule

[rtl/escape_sequence_decoder.sv]
// Escaped-string decoder. Raw bytes of a C-style escaped string enter on the
// in_ channel, one beat per byte, with in_last on the final byte. Unescaped
// bytes leave on the out_ channel, with out_last on the final byte that the
// string's last input produces; a string whose last input yields nothing
// gives no out_last beat.
// Both channels use valid/stall: a beat moves when valid is high and stall
// is low. One input byte is taken every cycle while in_stall is low. An
// accepted byte is held in the input register, is decoded in one pass and
// its 0 to 3 result bytes go into an 8-entry output queue that feeds out_.
// When the receiver stalls, the queue fills and in_stall rises once fewer
// than six entries are free, so that a multi-byte escape never overruns it.
// Sustained throughput is one input byte per cycle when each byte yields at
// most one result and the output side takes one byte per cycle.
// Reset (rst_n low, synchronous) empties the queue and returns the decoder
// to idle with no escape pending.
module escape_sequence_decoder import esd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);

`include "escape_sequence_decoder_defines.svh"

  logic       item_v_r, item_v_nxt;
  logic [7:0] item_byte_r;
  logic       item_last_r;
  res_t       res;
  fifo_stat_t stat;

  assign in_stall   = !stat.room;
  assign item_v_nxt = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_v_nxt) begin
      item_byte_r <= in_byte;
      item_last_r <= in_last;
    end
  end

  esd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_v    (item_v_r),
    .item_byte (item_byte_r),
    .item_last (item_last_r),
    .res       (res)
  );

  esd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  `ESD_ASSERT_NEVER(a_level_bound, stat.level > LVL_W'(FIFO_DEPTH))
  `ESD_ASSERT_IMPL(a_push_fits, item_v_r, stat.level <= LVL_W'(FIFO_DEPTH - MAX_RES))
  `ESD_ASSERT_NEXT(a_accept_loads, in_valid && !in_stall, item_v_r)
  `ESD_ASSERT_IMPL(a_idle_no_push, !item_v_r, res.cnt == 2'd0)

endmodule

[dv/tb_escape_sequence_decoder.sv]
module tb_escape_sequence_decoder;
  import esd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_COUNT  = 430;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  beat_t pending_q[$];
  beat_t unescaped_q[$];
  logic [7:0] step_bytes[$];

  // Decoder state as the testbench tracks it.
  mode_t      esc_mode = MODE_IDLE;
  logic [3:0] dig1 = 4'd0;
  logic [3:0] dig2 = 4'd0;
  logic [2:0] raw_left = 3'd0;

  logic [7:0] esc_letters[10] = '{CH_SLASH, CH_QUOTE, CH_A, CH_B, CH_F,
                                  CH_N, CH_R, CH_T, CH_V, CH_BSLASH};

  int unsigned cyc = 0;
  int unsigned quiet = 0;
  int          fails = 0;
  logic        calm;

  escape_sequence_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always #1 clk = ~clk;

  // Neither side idles inside this window.
  assign calm = (cyc >= 250) && (cyc < 500);

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic void plain_byte(logic [7:0] b);
    if (b == CH_BSLASH) begin
      esc_mode = MODE_ESC;
    end else begin
      esc_mode = MODE_IDLE;
      step_bytes.push_back(b);
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic l);
    beat_t r;
    step_bytes.delete();
    case (esc_mode)
      MODE_ESC: begin
        esc_mode = MODE_IDLE;
        case (b)
          CH_SLASH, CH_QUOTE, CH_BSLASH: step_bytes.push_back(b);
          CH_A: step_bytes.push_back(CTL_BEL);
          CH_B: step_bytes.push_back(CTL_BS);
          CH_F: step_bytes.push_back(CTL_FF);
          CH_N: step_bytes.push_back(CTL_LF);
          CH_R: step_bytes.push_back(CTL_CR);
          CH_T: step_bytes.push_back(CTL_TAB);
          CH_V: step_bytes.push_back(CTL_VT);
          CH_ZERO, CH_ONE: begin
            dig1 = b[3:0];
            esc_mode = MODE_ONE;
          end
          CH_U: begin
            step_bytes.push_back(CH_BSLASH);
            step_bytes.push_back(CH_U);
            raw_left = UESC_RAW;
            esc_mode = MODE_PASS;
          end
          default: begin
            step_bytes.push_back(CH_BSLASH);
            step_bytes.push_back(b);
          end
        endcase
      end
      MODE_ONE: begin
        if (is_digit(b)) begin
          dig2 = b[3:0];
          esc_mode = MODE_TWO;
        end else begin
          step_bytes.push_back(CH_BSLASH);
          plain_byte(b);
        end
      end
      MODE_TWO: begin
        if (is_digit(b)) begin
          step_bytes.push_back(8'(dig1 * 64 + dig2 * 8 + b[3:0]));
          esc_mode = MODE_IDLE;
        end else begin
          // The leading 0 or 1 is dropped; the held second digit comes out as text.
          step_bytes.push_back(CH_BSLASH);
          step_bytes.push_back(DIGIT_BASE + 8'(dig2));
          plain_byte(b);
        end
      end
      MODE_PASS: begin
        step_bytes.push_back(b);
        raw_left = raw_left - 3'd1;
        if (raw_left == 3'd0) esc_mode = MODE_IDLE;
      end
      default: plain_byte(b);
    endcase
    if (l) begin
      if (esc_mode == MODE_ESC || esc_mode == MODE_ONE) begin
        step_bytes.push_back(CH_BSLASH);
      end else if (esc_mode == MODE_TWO) begin
        step_bytes.push_back(CH_BSLASH);
        step_bytes.push_back(DIGIT_BASE + 8'(dig2));
      end
      esc_mode = MODE_IDLE;
      dig1 = 4'd0;
      dig2 = 4'd0;
      raw_left = 3'd0;
    end
    foreach (step_bytes[i]) begin
      r.data = step_bytes[i];
      r.last = l && (i == step_bytes.size() - 1);
      unescaped_q.push_back(r);
    end
  endfunction

  task automatic queue_beat(logic [7:0] b, logic l);
    pending_q.push_back('{data: b, last: l});
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) queue_beat(s[i], i == s.len() - 1);
  endtask

  // One string built from escape tokens with random content, sometimes cut short.
  task automatic queue_random_string();
    logic [7:0] s[$];
    int k;
    int cut;
    repeat ($urandom_range(5, 1)) begin
      k = $urandom_range(99);
      if (k < 30) begin
        s.push_back(8'($urandom_range(255)));
      end else if (k < 50) begin
        s.push_back(CH_BSLASH);
        s.push_back(esc_letters[$urandom_range(9)]);
      end else if (k < 65) begin
        s.push_back(CH_BSLASH);
        s.push_back(CH_ZERO + 8'($urandom_range(1)));
        s.push_back(CH_ZERO + 8'($urandom_range(9)));
        s.push_back(CH_ZERO + 8'($urandom_range(9)));
      end else if (k < 75) begin
        s.push_back(CH_BSLASH);
        s.push_back(CH_U);
        repeat (5) s.push_back(8'($urandom_range(255)));
      end else if (k < 87) begin
        s.push_back(CH_BSLASH);
        s.push_back(CH_ZERO + 8'($urandom_range(1)));
        if ($urandom_range(1) == 1) s.push_back(CH_ZERO + 8'($urandom_range(9)));
        s.push_back(8'($urandom_range(255)));
      end else begin
        s.push_back(CH_BSLASH);
        s.push_back(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(4) == 0) begin
      cut = $urandom_range(s.size() - 1);
      repeat (cut) void'(s.pop_back());
    end
    foreach (s[i]) queue_beat(s[i], i == s.size() - 1);
  endtask

  initial begin
    queue_beat(8'h00, 1'b0);
    queue_beat(8'hFF, 1'b1);
    queue_text("\\199\\0x");
    queue_text("\\v\\u1");
    queue_text("\\09");
    queue_text("\\");
    queue_text("\\1");
    queue_text("\\q");
    while (pending_q.size() < ITEM_COUNT) queue_random_string();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Sample at the falling edge so the driver's updates have all settled.
    while (pending_q.size() != 0 || in_valid || unescaped_q.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  always @(posedge clk) begin : drive
    beat_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_byte(in_byte, in_last);
      // A held beat stays put until it is taken.
      if (!in_valid || !in_stall) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 16)) begin
          nxt = pending_q.pop_front();
          in_valid <= 1'b1;
          in_byte <= nxt.data;
          in_last <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 16);
    end
  end

  always @(posedge clk) begin : check
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (unescaped_q.size() == 0) begin
        $error("out beat with nothing expected: out_byte %0h, out_last %0b",
               out_byte, out_last);
        fails++;
      end else begin
        want = unescaped_q.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte mismatch: expected %0h, got %0h", want.data, out_byte);
          fails++;
        end
        if (out_last !== want.last) begin
          $error("out_last mismatch: expected %0b, got %0b", want.last, out_last);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/esd_pkg.sv
rtl/esd_decode.sv
rtl/esd_fifo.sv
rtl/escape_sequence_decoder.sv
dv/tb_escape_sequence_decoder.sv
